FILE: src/odc_pkg.sv
package odc_pkg;

    localparam int CB_DEFAULT = 16;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    // Per-stage control that travels with every word in the pipeline.
    typedef struct packed {
        logic       valid;
        logic       kind;
        logic       fail;
        logic [2:0] neg;   // sign of x, y, z (bit 0 is x)
    } ctl_t;

endpackage

FILE: src/odc_front.sv
module odc_front
    import odc_pkg::*;
#(
    parameter int W = CB_DEFAULT,
    localparam int F  = W - 1,
    localparam int LW = W + 1,
    localparam int DW = W + 2,
    localparam int NW = W + F + 3,
    localparam int QW = 2 * F + 1,
    localparam int PW = 4 * F + 6
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic                   in_kind,
    input  logic [W-1:0]           in_x,
    input  logic [W-1:0]           in_y,
    input  logic [W-1:0]           in_z,
    input  logic [W-1:0]           in_u,
    input  logic [W-1:0]           in_v,
    output ctl_t                   ctl_o,
    output logic [1:0][NW-1:0]     rem_o,
    output logic [DW-1:0]          den_o,
    output logic [QW-1:0]          q_o,
    output logic [2:0][PW-1:0]     r_o
);

    localparam logic [W-1:0]  ONE  = W'(1) << F;
    localparam logic [W-1:0]  HALF = W'(1) << (F - 1);
    localparam logic [LW-1:0] ONE1 = LW'(ONE);

    // stage 1: magnitudes, L1 norm, decode unfold prep
    ctl_t          ctl1_next, ctl1_reg;
    logic [W-1:0]  e_ax, e_ay, e_az, d_ax, d_ay, d_az;
    logic [LW-1:0] e_l1, d_s, tu, tv;
    logic          d_xn, d_yn, d_zn;
    logic [W-1:0]  ax1_reg, ay1_reg, az1_reg;
    logic [LW-1:0] l1_reg;

    always_comb begin
        e_ax = in_x[W-1] ? (~in_x + 1'b1) : in_x;
        e_ay = in_y[W-1] ? (~in_y + 1'b1) : in_y;
        e_az = in_z[W-1] ? (~in_z + 1'b1) : in_z;
        e_l1 = LW'(e_ax) + LW'(e_ay) + LW'(e_az);

        tu   = {in_u, 1'b0};
        tv   = {in_v, 1'b0};
        d_xn = in_u < HALF;
        d_yn = in_v < HALF;
        d_ax = d_xn ? W'(ONE1 - tu) : W'(tu - ONE1);
        d_ay = d_yn ? W'(ONE1 - tv) : W'(tv - ONE1);
        d_s  = LW'(d_ax) + LW'(d_ay);
        d_zn = d_s > ONE1;
        d_az = d_zn ? W'(d_s - ONE1) : W'(ONE1 - d_s);

        ctl1_next.valid = in_valid;
        ctl1_next.kind  = in_kind;
        if (in_kind == KIND_DECODE) begin
            ctl1_next.fail = (in_u > ONE) || (in_v > ONE);
            ctl1_next.neg  = {d_zn, d_yn, d_xn};
        end else begin
            ctl1_next.fail = (e_l1 == '0);
            ctl1_next.neg  = {in_z[W-1], in_y[W-1], in_x[W-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
        end else if (en) begin
            ctl1_reg <= ctl1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg <= (in_kind == KIND_DECODE) ? d_ax : e_ax;
            ay1_reg <= (in_kind == KIND_DECODE) ? d_ay : e_ay;
            az1_reg <= d_az;
            l1_reg  <= e_l1;
        end
    end

    // stage 2: fold lower hemisphere, form dividends
    logic [DW-1:0]        nu, nv, l1x, l1d;
    logic [1:0][NW-1:0]   rem2_next, rem2_reg;
    logic [2:0][W-1:0]    mag2_next, mag2_reg;
    logic [DW-1:0]        den2_reg;
    ctl_t                 ctl2_reg;
    logic                 fold;

    always_comb begin
        fold = ctl1_reg.neg[2];
        l1x  = DW'(l1_reg);
        l1d  = l1x << 1;
        if (fold) begin
            nu = ctl1_reg.neg[0] ? DW'(ay1_reg) : l1d - DW'(ay1_reg);
            nv = ctl1_reg.neg[1] ? DW'(ax1_reg) : l1d - DW'(ax1_reg);
        end else begin
            nu = ctl1_reg.neg[0] ? l1x - DW'(ax1_reg) : l1x + DW'(ax1_reg);
            nv = ctl1_reg.neg[1] ? l1x - DW'(ay1_reg) : l1x + DW'(ay1_reg);
        end
        rem2_next[0] = (NW'(nu) << F) + NW'(l1_reg);
        rem2_next[1] = (NW'(nv) << F) + NW'(l1_reg);
        mag2_next[0] = fold ? ONE - ay1_reg : ax1_reg;
        mag2_next[1] = fold ? ONE - ax1_reg : ay1_reg;
        mag2_next[2] = az1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl2_reg <= '0;
        end else if (en) begin
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem2_reg <= rem2_next;
            den2_reg <= l1d;
            mag2_reg <= mag2_next;
        end
    end

    // stage 3: squares
    ctl_t                 ctl3_reg;
    logic [1:0][NW-1:0]   rem3_reg;
    logic [DW-1:0]        den3_reg;
    logic [2:0][QW-1:0]   sq3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl3_reg <= '0;
        end else if (en) begin
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem3_reg <= rem2_reg;
            den3_reg <= den2_reg;
            for (int i = 0; i < 3; i++) begin
                sq3_reg[i] <= QW'(mag2_reg[i] * mag2_reg[i]);
            end
        end
    end

    // stage 4: squared length and per-component targets
    ctl_t                 ctl4_reg;
    logic [1:0][NW-1:0]   rem4_reg;
    logic [DW-1:0]        den4_reg;
    logic [QW-1:0]        q4_reg;
    logic [2:0][PW-1:0]   r4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl4_reg <= '0;
        end else if (en) begin
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem4_reg <= rem3_reg;
            den4_reg <= den3_reg;
            q4_reg   <= sq3_reg[0] + sq3_reg[1] + sq3_reg[2];
            for (int i = 0; i < 3; i++) begin
                r4_reg[i] <= PW'(sq3_reg[i]) << (2 * F + 2);
            end
        end
    end

    assign ctl_o = ctl4_reg;
    assign rem_o = rem4_reg;
    assign den_o = den4_reg;
    assign q_o   = q4_reg;
    assign r_o   = r4_reg;

endmodule

FILE: src/odc_step.sv
module odc_step
    import odc_pkg::*;
#(
    parameter int W = CB_DEFAULT,
    parameter int K = 0,
    localparam int F  = W - 1,
    localparam int DW = W + 2,
    localparam int NW = W + F + 3,
    localparam int QW = 2 * F + 1,
    localparam int PW = 4 * F + 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  ctl_t                 ctl_i,
    input  logic [1:0][NW-1:0]   rem_i,
    input  logic [DW-1:0]        den_i,
    input  logic [QW-1:0]        q_i,
    input  logic [2:0][PW-1:0]   r_i,
    input  logic [2:0][PW-1:0]   s1_i,
    input  logic [2:0][PW-1:0]   s2_i,
    input  logic [2:0][W-1:0]    acc_i,
    output ctl_t                 ctl_o,
    output logic [1:0][NW-1:0]   rem_o,
    output logic [DW-1:0]        den_o,
    output logic [QW-1:0]        q_o,
    output logic [2:0][PW-1:0]   r_o,
    output logic [2:0][PW-1:0]   s1_o,
    output logic [2:0][PW-1:0]   s2_o,
    output logic [2:0][W-1:0]    acc_o
);

    // One quotient bit of the encode division and one bit of the decode
    // rounding search. The search keeps m*q and m*m*q so that the test
    // (2m-1)^2 q <= 4 a^2 ONE^2 needs only shifts and adds.
    logic [NW-1:0]        dk;
    logic [PW-1:0]        qx;
    logic [1:0]           take_e;
    logic [2:0]           take_d;
    logic [2:0][PW-1:0]   s1c, s2c;
    logic [1:0][NW-1:0]   rem_next, rem_reg;
    logic [2:0][PW-1:0]   s1_next, s2_next, s1_reg, s2_reg, r_reg;
    logic [2:0][W-1:0]    acc_next, acc_reg;
    logic [DW-1:0]        den_reg;
    logic [QW-1:0]        q_reg;
    ctl_t                 ctl_reg;

    always_comb begin
        dk = NW'(den_i) << K;
        qx = PW'(q_i);
        for (int i = 0; i < 2; i++) begin
            take_e[i]   = rem_i[i] >= dk;
            rem_next[i] = take_e[i] ? rem_i[i] - dk : rem_i[i];
        end
        for (int i = 0; i < 3; i++) begin
            s1c[i]     = s1_i[i] + (qx << K);
            s2c[i]     = s2_i[i] + (s1_i[i] << (K + 1)) + (qx << (2 * K));
            take_d[i]  = ((s2c[i] << 2) + qx) <= (r_i[i] + (s1c[i] << 2));
            s1_next[i] = take_d[i] ? s1c[i] : s1_i[i];
            s2_next[i] = take_d[i] ? s2c[i] : s2_i[i];
        end
        acc_next = acc_i;
        if (ctl_i.kind == KIND_DECODE) begin
            for (int i = 0; i < 3; i++) begin
                acc_next[i][K] = take_d[i];
            end
        end else begin
            for (int i = 0; i < 2; i++) begin
                acc_next[i][K] = take_e[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            den_reg <= den_i;
            q_reg   <= q_i;
            r_reg   <= r_i;
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            acc_reg <= acc_next;
        end
    end

    assign ctl_o = ctl_reg;
    assign rem_o = rem_reg;
    assign den_o = den_reg;
    assign q_o   = q_reg;
    assign r_o   = r_reg;
    assign s1_o  = s1_reg;
    assign s2_o  = s2_reg;
    assign acc_o = acc_reg;

endmodule

FILE: src/odc_back.sv
module odc_back
    import odc_pkg::*;
#(
    parameter int W = CB_DEFAULT,
    localparam int F = W - 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  ctl_t              ctl_i,
    input  logic [2:0][W-1:0] acc_i,
    output logic              valid_o,
    output logic [W-1:0]      u_o,
    output logic [W-1:0]      v_o,
    output logic [2:0][W-1:0] dir_o,
    output logic              ok_o
);

    localparam logic [W-1:0] ONE  = W'(1) << F;
    localparam logic [W-1:0] HALF = W'(1) << (F - 1);
    localparam logic [W-1:0] MAXP = ONE - 1'b1;

    logic              valid_reg, ok_next, ok_reg;
    logic [W-1:0]      u_next, v_next, u_reg, v_reg;
    logic [2:0][W-1:0] dir_next, dir_reg;

    always_comb begin
        u_next   = '0;
        v_next   = '0;
        dir_next = '0;
        ok_next  = !ctl_i.fail;
        if (ctl_i.kind == KIND_DECODE) begin
            if (ctl_i.fail) begin
                dir_next[2] = MAXP;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    if (ctl_i.neg[i]) begin
                        dir_next[i] = ~acc_i[i] + 1'b1;
                    end else begin
                        // a full-scale positive component saturates
                        dir_next[i] = acc_i[i][F] ? MAXP : acc_i[i];
                    end
                end
            end
        end else begin
            u_next = ctl_i.fail ? HALF : acc_i[0];
            v_next = ctl_i.fail ? HALF : acc_i[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_i.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg   <= u_next;
            v_reg   <= v_next;
            dir_reg <= dir_next;
            ok_reg  <= ok_next;
        end
    end

    assign valid_o = valid_reg;
    assign u_o     = u_reg;
    assign v_o     = v_reg;
    assign dir_o   = dir_reg;
    assign ok_o    = ok_reg;

endmodule

FILE: src/octahedral_direction_codec_unit.sv
// channel | dir | tdata fields (lsb first)              | tuser
// s_      | in  | in_dir_x, in_dir_y, in_dir_z, in_u, in_v | kind
// m_      | out | out_u, out_v, out_dir_x, out_dir_y, out_dir_z | ok
//
// One word per cycle while no result waits on m_tready. The pipeline is
// four front stages, one stage per quotient bit of the divide/rounding
// search (COMPONENT_BITS stages), one output register.
// Reset clears every valid bit; payload registers are not reset.
// The whole pipeline holds while a result waits on m_tready.
module octahedral_direction_codec_unit
    import odc_pkg::*;
#(
    parameter int COMPONENT_BITS = CB_DEFAULT,
    localparam int TDW = ((5 * COMPONENT_BITS + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [TDW-1:0] s_tdata,   // in_dir_x, in_dir_y, in_dir_z, in_u, in_v
    input  logic           s_tuser,   // kind
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [TDW-1:0] m_tdata,   // out_u, out_v, out_dir_x, out_dir_y, out_dir_z
    output logic           m_tuser    // ok
);

    localparam int W  = COMPONENT_BITS;
    localparam int F  = W - 1;
    localparam int DW = W + 2;
    localparam int NW = W + F + 3;
    localparam int QW = 2 * F + 1;
    localparam int PW = 4 * F + 6;
    localparam int NS = F + 1;

    logic adv;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    ctl_t               ctl_w [NS+1];
    logic [1:0][NW-1:0] rem_w [NS+1];
    logic [DW-1:0]      den_w [NS+1];
    logic [QW-1:0]      q_w   [NS+1];
    logic [2:0][PW-1:0] r_w   [NS+1];
    logic [2:0][PW-1:0] s1_w  [NS+1];
    logic [2:0][PW-1:0] s2_w  [NS+1];
    logic [2:0][W-1:0]  acc_w [NS+1];

    odc_front #(.W(W)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_x     (s_tdata[0*W +: W]),
        .in_y     (s_tdata[1*W +: W]),
        .in_z     (s_tdata[2*W +: W]),
        .in_u     (s_tdata[3*W +: W]),
        .in_v     (s_tdata[4*W +: W]),
        .ctl_o    (ctl_w[0]),
        .rem_o    (rem_w[0]),
        .den_o    (den_w[0]),
        .q_o      (q_w[0]),
        .r_o      (r_w[0])
    );

    assign s1_w[0]  = '0;
    assign s2_w[0]  = '0;
    assign acc_w[0] = '0;

    for (genvar j = 0; j < NS; j++) begin : g_step
        odc_step #(.W(W), .K(F - j)) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .ctl_i   (ctl_w[j]),
            .rem_i   (rem_w[j]),
            .den_i   (den_w[j]),
            .q_i     (q_w[j]),
            .r_i     (r_w[j]),
            .s1_i    (s1_w[j]),
            .s2_i    (s2_w[j]),
            .acc_i   (acc_w[j]),
            .ctl_o   (ctl_w[j+1]),
            .rem_o   (rem_w[j+1]),
            .den_o   (den_w[j+1]),
            .q_o     (q_w[j+1]),
            .r_o     (r_w[j+1]),
            .s1_o    (s1_w[j+1]),
            .s2_o    (s2_w[j+1]),
            .acc_o   (acc_w[j+1])
        );
    end

    logic [W-1:0]      out_u, out_v;
    logic [2:0][W-1:0] out_dir;

    odc_back #(.W(W)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .ctl_i   (ctl_w[NS]),
        .acc_i   (acc_w[NS]),
        .valid_o (m_tvalid),
        .u_o     (out_u),
        .v_o     (out_v),
        .dir_o   (out_dir),
        .ok_o    (m_tuser)
    );

    assign m_tdata = TDW'({out_dir[2], out_dir[1], out_dir[0], out_v, out_u});

endmodule

FILE: src/odc_check.sv
module odc_check
    import odc_pkg::*;
#(
    parameter int W = CB_DEFAULT,
    localparam int TDW = ((5 * W + 7) / 8) * 8
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_tready,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [TDW-1:0] m_tdata,
    input logic           m_tuser
);

    localparam logic [W-1:0] ONE  = W'(1) << (W - 1);
    localparam logic [W-1:0] HALF = W'(1) << (W - 2);
    localparam logic [W-1:0] MAXP = ONE - 1'b1;

    logic [W-1:0] fu, fv, fx, fy, fz;

    assign fu = m_tdata[0*W +: W];
    assign fv = m_tdata[1*W +: W];
    assign fx = m_tdata[2*W +: W];
    assign fy = m_tdata[3*W +: W];
    assign fz = m_tdata[4*W +: W];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            (fu == HALF && fv == HALF && fx == '0 && fy == '0 && fz == '0) ||
            (fu == '0 && fv == '0 && fx == '0 && fy == '0 && fz == MAXP))
        else $error("failed conversion with wrong fill value");

    a_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (fx == '0 && fy == '0 && fz == '0) || (fu == '0 && fv == '0))
        else $error("encode and decode fields mixed");

endmodule

bind octahedral_direction_codec_unit odc_check #(.W(COMPONENT_BITS)) u_odc_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
